// ===== hw/rtl/atc_pkg.sv =====
// Shared types, constants and tables of the affine transform composer.
package atc_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int WORD_W           = 32;
   localparam int ANGLE_W          = 27;
   localparam int MODE_W           = 3;
   localparam int QUEUE_DEPTH      = 2;
   localparam int K_W              = 34;
   localparam int ACC_W            = 66;
   localparam int PC_W             = 5;

   // Fractions of a turn per degree and per radian, scaled by 2^36
   localparam logic [K_W-1:0]        TURN_PER_DEG = 34'd190887435;
   localparam logic [K_W-1:0]        TURN_PER_RAD = 34'd10937044409;
   localparam logic [31:0]           PI_Q30       = 32'd3373259426;
   localparam logic signed [33:0]    GAIN_Q30     = 34'sd652032874;

   localparam logic [MODE_W-1:0] MODE_IDENT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TRANS = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ROT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SCALE = 3'd4;

   // Microprogram entry points
   localparam logic [PC_W-1:0] PC_SCALE = 5'd0;
   localparam logic [PC_W-1:0] PC_ROT   = 5'd2;
   localparam logic [PC_W-1:0] PC_LOAD  = 5'd6;
   localparam logic [PC_W-1:0] PC_POST  = 5'd12;

   typedef enum logic [2:0] {
      CLS_IDENT, CLS_LOAD, CLS_TRANS, CLS_ROT, CLS_SCALE, CLS_NOP
   } class_type;

   typedef struct packed {
      class_type                  cls;
      logic signed [WORD_W-1:0]   px;
      logic signed [WORD_W-1:0]   py;
      logic signed [WORD_W-1:0]   ox;
      logic signed [WORD_W-1:0]   oy;
      logic signed [ANGLE_W-1:0]  angle;
      logic signed [WORD_W-1:0]   sx;
      logic signed [WORD_W-1:0]   sy;
   } cmd_type;

   typedef struct packed {
      logic                       start;
      logic                       degrees;
      logic signed [ANGLE_W-1:0]  angle;
   } cordic_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [WORD_W-1:0]   cs;
      logic signed [WORD_W-1:0]   sn;
   } cordic_rsp_type;

   typedef enum logic [3:0] {
      OP_M0, OP_M1, OP_M2, OP_M3, OP_F0, OP_F1, OP_F2, OP_F3,
      OP_F4, OP_F5, OP_PX, OP_PY, OP_SX, OP_SY, OP_CS, OP_SN
   } op_sel_type;

   typedef enum logic [2:0] {
      BASE_ZERO, BASE_PX, BASE_PY, BASE_PXOX, BASE_PYOY, BASE_M4, BASE_M5, BASE_ACC
   } base_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_F0, DST_F2, DST_F4, DST_F5,
      DST_N0, DST_N1, DST_N2, DST_N3, DST_N4, DST_N5
   } dest_type;

   typedef struct packed {
      op_sel_type a_sel;
      op_sel_type b_sel;
      base_type   base;
      logic       sub;
      dest_type   dest;
      logic       jump;
      logic       done;
   } uop_type;

   typedef enum logic [2:0] {
      C_IDLE, C_MUL_LO, C_MUL_HI, C_FOLD, C_SCALE, C_ITER, C_ROUND
   } cordic_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_CORDIC, B_MUL, B_ACC, B_COMMIT, B_OUT
   } back_state_type;

   function automatic logic [30:0] atan_q30(input logic [4:0] i);
      logic [30:0] v;
      case (i)
         5'd0:    v = 31'd843314857;
         5'd1:    v = 31'd497837829;
         5'd2:    v = 31'd263043837;
         5'd3:    v = 31'd133525159;
         5'd4:    v = 31'd67021687;
         5'd5:    v = 31'd33543516;
         5'd6:    v = 31'd16775851;
         5'd7:    v = 31'd8388437;
         5'd8:    v = 31'd4194283;
         5'd9:    v = 31'd2097149;
         5'd31:   v = 31'd0;
         default: v = 31'd1 << (5'd30 - i);
      endcase
      return v;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
      lo = {{(ACC_W-31){1'b1}}, 31'd0};
      if (v > hi) return hi[WORD_W-1:0];
      if (v < lo) return lo[WORD_W-1:0];
      return v[WORD_W-1:0];
   endfunction

   function automatic uop_type mk(input op_sel_type a, input op_sel_type b, input base_type bs,
                                  input logic sub, input dest_type d, input logic jump,
                                  input logic done);
      uop_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.base  = bs;
      u.sub   = sub;
      u.dest  = d;
      u.jump  = jump;
      u.done  = done;
      return u;
   endfunction

   // One product per step; the last step of each sum writes its destination
   function automatic uop_type uop_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         5'd0:    u = mk(OP_SX, OP_PX, BASE_PX,   1'b1, DST_F4,   1'b0, 1'b0);
         5'd1:    u = mk(OP_SY, OP_PY, BASE_PY,   1'b1, DST_F5,   1'b1, 1'b0);
         5'd2:    u = mk(OP_CS, OP_PX, BASE_PX,   1'b1, DST_NONE, 1'b0, 1'b0);
         5'd3:    u = mk(OP_SN, OP_PY, BASE_ACC,  1'b0, DST_F4,   1'b0, 1'b0);
         5'd4:    u = mk(OP_SN, OP_PX, BASE_PY,   1'b1, DST_NONE, 1'b0, 1'b0);
         5'd5:    u = mk(OP_CS, OP_PY, BASE_ACC,  1'b1, DST_F5,   1'b1, 1'b0);
         5'd6:    u = mk(OP_SX, OP_CS, BASE_ZERO, 1'b0, DST_F0,   1'b0, 1'b0);
         5'd7:    u = mk(OP_SX, OP_SN, BASE_ZERO, 1'b0, DST_F2,   1'b0, 1'b0);
         5'd8:    u = mk(OP_F0, OP_PX, BASE_PXOX, 1'b1, DST_NONE, 1'b0, 1'b0);
         5'd9:    u = mk(OP_F2, OP_PY, BASE_ACC,  1'b0, DST_N4,   1'b0, 1'b0);
         5'd10:   u = mk(OP_F2, OP_PX, BASE_PYOY, 1'b1, DST_NONE, 1'b0, 1'b0);
         5'd11:   u = mk(OP_F0, OP_PY, BASE_ACC,  1'b1, DST_N5,   1'b0, 1'b1);
         5'd12:   u = mk(OP_M0, OP_F0, BASE_ZERO, 1'b0, DST_NONE, 1'b0, 1'b0);
         5'd13:   u = mk(OP_M1, OP_F2, BASE_ACC,  1'b0, DST_N0,   1'b0, 1'b0);
         5'd14:   u = mk(OP_M0, OP_F1, BASE_ZERO, 1'b0, DST_NONE, 1'b0, 1'b0);
         5'd15:   u = mk(OP_M1, OP_F3, BASE_ACC,  1'b0, DST_N1,   1'b0, 1'b0);
         5'd16:   u = mk(OP_M2, OP_F0, BASE_ZERO, 1'b0, DST_NONE, 1'b0, 1'b0);
         5'd17:   u = mk(OP_M3, OP_F2, BASE_ACC,  1'b0, DST_N2,   1'b0, 1'b0);
         5'd18:   u = mk(OP_M2, OP_F1, BASE_ZERO, 1'b0, DST_NONE, 1'b0, 1'b0);
         5'd19:   u = mk(OP_M3, OP_F3, BASE_ACC,  1'b0, DST_N3,   1'b0, 1'b0);
         5'd20:   u = mk(OP_M0, OP_F4, BASE_M4,   1'b0, DST_NONE, 1'b0, 1'b0);
         5'd21:   u = mk(OP_M1, OP_F5, BASE_ACC,  1'b0, DST_N4,   1'b0, 1'b0);
         5'd22:   u = mk(OP_M2, OP_F4, BASE_M5,   1'b0, DST_NONE, 1'b0, 1'b0);
         5'd23:   u = mk(OP_M3, OP_F5, BASE_ACC,  1'b0, DST_N5,   1'b0, 1'b1);
         default: u = mk(OP_M0, OP_M0, BASE_ZERO, 1'b0, DST_NONE, 1'b0, 1'b1);
      endcase
      return u;
   endfunction

endpackage

// ===== hw/rtl/atc_front.sv =====
// Front end: accepts commands, classifies the mode and queues them for the back end.
module atc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [atc_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_offset_x,
   input  logic signed [31:0]            req_offset_y,
   input  logic signed [26:0]            req_angle,
   input  logic signed [31:0]            req_scale_x,
   input  logic signed [31:0]            req_scale_y,
   output logic                          q_valid,
   output atc_pkg::cmd_type              q_cmd,
   input  logic                          q_pop
);
   import atc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          cmd_new;
   logic             push;
   logic             pop;

   always_comb begin
      unique case (req_mode)
         MODE_IDENT: cmd_new.cls = CLS_IDENT;
         MODE_LOAD:  cmd_new.cls = CLS_LOAD;
         MODE_TRANS: cmd_new.cls = CLS_TRANS;
         MODE_ROT:   cmd_new.cls = CLS_ROT;
         MODE_SCALE: cmd_new.cls = CLS_SCALE;
         default:    cmd_new.cls = CLS_NOP;
      endcase
      cmd_new.px    = req_point_x;
      cmd_new.py    = req_point_y;
      cmd_new.ox    = req_offset_x;
      cmd_new.oy    = req_offset_y;
      cmd_new.angle = req_angle;
      cmd_new.sx    = req_scale_x;
      cmd_new.sy    = req_scale_y;
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(push) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== hw/rtl/atc_cordic.sv =====
// Iterative sine and cosine unit: angle to phase, quadrant fold, one CORDIC step a cycle.
module atc_cordic #(
   parameter int FRAC_BITS    = atc_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  atc_pkg::cordic_req_type  req,
   output atc_pkg::cordic_rsp_type  rsp
);
   import atc_pkg::*;

   localparam int IW    = $clog2(CORDIC_STEPS);
   localparam int PH_LO = FRAC_BITS + 4;
   localparam logic signed [33:0] RHALF = 34'sd1 <<< (29 - FRAC_BITS);

   cordic_state_type           state_ff, state_in;
   logic signed [ANGLE_W-1:0]  ang_ff, ang_in;
   logic [K_W-1:0]             k_ff, k_in;
   logic signed [44:0]         plo_ff, plo_in;
   logic signed [44:0]         phi_ff, phi_in;
   logic [30:0]                mag_ff, mag_in;
   logic                       rneg_ff, rneg_in;
   logic                       neg_ff, neg_in;
   logic signed [33:0]         x_ff, x_in;
   logic signed [33:0]         y_ff, y_in;
   logic signed [33:0]         z_ff, z_in;
   logic [IW-1:0]              i_ff, i_in;
   logic                       done_ff, done_in;
   logic signed [WORD_W-1:0]   cs_ff, cs_in;
   logic signed [WORD_W-1:0]   sn_ff, sn_in;

   logic signed [61:0] prod;
   logic [31:0]        phase;
   logic [31:0]        phase_f;
   logic signed [31:0] r;
   logic [62:0]        scaled;
   logic [31:0]        zmag;
   logic signed [33:0] zpos;
   logic signed [33:0] xs;
   logic signed [33:0] ys;
   logic signed [33:0] at;
   logic signed [33:0] xr;
   logic signed [33:0] yr;

   always_comb begin
      state_in = state_ff;
      ang_in   = ang_ff;
      k_in     = k_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      mag_in   = mag_ff;
      rneg_in  = rneg_ff;
      neg_in   = neg_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      done_in  = 1'b0;
      cs_in    = cs_ff;
      sn_in    = sn_ff;

      prod    = (62'(phi_ff) <<< 17) + 62'(plo_ff);
      phase   = prod[PH_LO+31:PH_LO];
      phase_f = {phase[31] ^ phase[30] ^ phase[31], phase[30:0]};
      // Phase in the left half-plane is moved by half a turn
      phase_f[31] = phase[30];
      r       = signed'(phase_f);
      scaled  = 63'(mag_ff) * 63'(PI_Q30);
      zmag    = 32'((scaled + (63'd1 << 30)) >> 31);
      zpos    = signed'(34'(zmag));
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      at      = signed'(34'(atan_q30(5'(i_ff))));
      xr      = (x_ff + RHALF) >>> (30 - FRAC_BITS);
      yr      = (y_ff + RHALF) >>> (30 - FRAC_BITS);

      unique case (state_ff)
         C_IDLE: begin
            if (req.start) begin
               ang_in   = req.angle;
               k_in     = req.degrees ? TURN_PER_DEG : TURN_PER_RAD;
               state_in = C_MUL_LO;
            end
         end
         C_MUL_LO: begin
            plo_in   = 45'(ang_ff * signed'({1'b0, k_ff[16:0]}));
            state_in = C_MUL_HI;
         end
         C_MUL_HI: begin
            phi_in   = 45'(ang_ff * signed'({1'b0, k_ff[K_W-1:17]}));
            state_in = C_FOLD;
         end
         C_FOLD: begin
            neg_in   = phase[31] ^ phase[30];
            rneg_in  = r[31];
            mag_in   = r[31] ? 31'(-33'(r)) : 31'(r);
            state_in = C_SCALE;
         end
         C_SCALE: begin
            z_in     = rneg_ff ? -zpos : zpos;
            x_in     = GAIN_Q30;
            y_in     = '0;
            i_in     = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            i_in = IW'(i_ff + 1'b1);
            if (i_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            cs_in    = neg_ff ? 32'(-xr) : 32'(xr);
            sn_in    = neg_ff ? 32'(-yr) : 32'(yr);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      ang_ff  <= ang_in;
      k_ff    <= k_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      mag_ff  <= mag_in;
      rneg_ff <= rneg_in;
      neg_ff  <= neg_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      cs_ff   <= cs_in;
      sn_ff   <= sn_in;
   end

   assign rsp.done = done_ff;
   assign rsp.cs   = cs_ff;
   assign rsp.sn   = sn_ff;

endmodule

// ===== hw/rtl/atc_back.sv =====
// Back end: microprogrammed multiply-accumulate over the matrix, with the result register.
module atc_back #(
   parameter int FRAC_BITS    = atc_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  atc_pkg::cmd_type   q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_m_xx,
   output logic signed [31:0] rsp_m_xy,
   output logic signed [31:0] rsp_m_yx,
   output logic signed [31:0] rsp_m_yy,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y
);
   import atc_pkg::*;

   localparam logic signed [WORD_W-1:0] ONE  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0]       HALF = 64'sd1 <<< (FRAC_BITS - 1);

   back_state_type            state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic signed [WORD_W-1:0]  m_ff [6];
   logic signed [WORD_W-1:0]  m_in [6];
   logic signed [WORD_W-1:0]  f_ff [6];
   logic signed [WORD_W-1:0]  f_in [6];
   logic signed [WORD_W-1:0]  n_ff [6];
   logic signed [WORD_W-1:0]  n_in [6];
   logic signed [WORD_W-1:0]  o_ff [6];
   logic signed [WORD_W-1:0]  o_in [6];
   logic signed [WORD_W-1:0]  cs_ff, cs_in;
   logic signed [WORD_W-1:0]  sn_ff, sn_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [PC_W-1:0]           pc_ff, pc_in;
   logic                      valid_ff, valid_in;

   cordic_req_type            creq;
   cordic_rsp_type            crsp;
   uop_type                   uop;
   logic signed [WORD_W-1:0]  opa;
   logic signed [WORD_W-1:0]  opb;
   logic signed [ACC_W-1:0]   base;
   logic signed [63:0]        rnd;
   logic signed [WORD_W-1:0]  wval;

   atc_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (creq),
      .rsp   (crsp)
   );

   function automatic logic signed [WORD_W-1:0] pick(
      input op_sel_type s, input cmd_type c,
      input logic signed [WORD_W-1:0] m0, input logic signed [WORD_W-1:0] m1,
      input logic signed [WORD_W-1:0] m2, input logic signed [WORD_W-1:0] m3,
      input logic signed [WORD_W-1:0] f0, input logic signed [WORD_W-1:0] f1,
      input logic signed [WORD_W-1:0] f2, input logic signed [WORD_W-1:0] f3,
      input logic signed [WORD_W-1:0] f4, input logic signed [WORD_W-1:0] f5,
      input logic signed [WORD_W-1:0] cs, input logic signed [WORD_W-1:0] sn);
      logic signed [WORD_W-1:0] v;
      case (s)
         OP_M0:   v = m0;
         OP_M1:   v = m1;
         OP_M2:   v = m2;
         OP_M3:   v = m3;
         OP_F0:   v = f0;
         OP_F1:   v = f1;
         OP_F2:   v = f2;
         OP_F3:   v = f3;
         OP_F4:   v = f4;
         OP_F5:   v = f5;
         OP_PX:   v = c.px;
         OP_PY:   v = c.py;
         OP_SX:   v = c.sx;
         OP_SY:   v = c.sy;
         OP_CS:   v = cs;
         default: v = sn;
      endcase
      return v;
   endfunction

   always_comb begin
      uop = uop_rom(pc_ff);
      opa = pick(uop.a_sel, cmd_ff, m_ff[0], m_ff[1], m_ff[2], m_ff[3],
                 f_ff[0], f_ff[1], f_ff[2], f_ff[3], f_ff[4], f_ff[5], cs_ff, sn_ff);
      opb = pick(uop.b_sel, cmd_ff, m_ff[0], m_ff[1], m_ff[2], m_ff[3],
                 f_ff[0], f_ff[1], f_ff[2], f_ff[3], f_ff[4], f_ff[5], cs_ff, sn_ff);
      case (uop.base)
         BASE_ZERO: base = '0;
         BASE_PX:   base = ACC_W'(cmd_ff.px);
         BASE_PY:   base = ACC_W'(cmd_ff.py);
         BASE_PXOX: base = ACC_W'(cmd_ff.px) + ACC_W'(cmd_ff.ox);
         BASE_PYOY: base = ACC_W'(cmd_ff.py) + ACC_W'(cmd_ff.oy);
         BASE_M4:   base = ACC_W'(m_ff[4]);
         BASE_M5:   base = ACC_W'(m_ff[5]);
         default:   base = acc_ff;
      endcase
      rnd = (prod_ff + HALF) >>> FRAC_BITS;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      m_in     = m_ff;
      f_in     = f_ff;
      n_in     = n_ff;
      o_in     = o_ff;
      cs_in    = cs_ff;
      sn_in    = sn_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      pc_in    = pc_ff;
      valid_in = valid_ff;
      q_pop    = 1'b0;
      creq.start   = 1'b0;
      creq.degrees = 1'b0;
      creq.angle   = q_cmd.angle;
      wval     = '0;

      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.cls)
                  CLS_IDENT: begin
                     m_in[0]  = ONE;
                     m_in[1]  = '0;
                     m_in[2]  = '0;
                     m_in[3]  = ONE;
                     m_in[4]  = '0;
                     m_in[5]  = '0;
                     state_in = B_OUT;
                  end
                  CLS_TRANS: begin
                     f_in[0]  = ONE;
                     f_in[1]  = '0;
                     f_in[2]  = '0;
                     f_in[3]  = ONE;
                     f_in[4]  = q_cmd.px;
                     f_in[5]  = q_cmd.py;
                     pc_in    = PC_POST;
                     state_in = B_MUL;
                  end
                  CLS_SCALE: begin
                     f_in[0]  = q_cmd.sx;
                     f_in[1]  = '0;
                     f_in[2]  = '0;
                     f_in[3]  = q_cmd.sy;
                     pc_in    = PC_SCALE;
                     state_in = B_MUL;
                  end
                  CLS_ROT, CLS_LOAD: begin
                     creq.start   = 1'b1;
                     creq.degrees = (q_cmd.cls == CLS_LOAD);
                     state_in     = B_CORDIC;
                  end
                  default: state_in = B_OUT;
               endcase
            end
         end
         B_CORDIC: begin
            if (crsp.done) begin
               cs_in = crsp.cs;
               sn_in = crsp.sn;
               if (cmd_ff.cls == CLS_ROT) begin
                  f_in[0] = crsp.cs;
                  f_in[1] = sat32(-ACC_W'(crsp.sn));
                  f_in[2] = crsp.sn;
                  f_in[3] = crsp.cs;
                  pc_in   = PC_ROT;
               end else begin
                  pc_in   = PC_LOAD;
               end
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in  = opa * opb;
            state_in = B_ACC;
         end
         B_ACC: begin
            acc_in = uop.sub ? base - ACC_W'(rnd) : base + ACC_W'(rnd);
            wval   = sat32(acc_in);
            case (uop.dest)
               DST_F0:  f_in[0] = wval;
               DST_F2:  f_in[2] = wval;
               DST_F4:  f_in[4] = wval;
               DST_F5:  f_in[5] = wval;
               DST_N0:  n_in[0] = wval;
               DST_N1:  n_in[1] = wval;
               DST_N2:  n_in[2] = wval;
               DST_N3:  n_in[3] = wval;
               DST_N4:  n_in[4] = wval;
               DST_N5:  n_in[5] = wval;
               default: ;
            endcase
            if (uop.done) begin
               state_in = B_COMMIT;
            end else begin
               pc_in    = uop.jump ? PC_POST : PC_W'(pc_ff + 1'b1);
               state_in = B_MUL;
            end
         end
         B_COMMIT: begin
            if (cmd_ff.cls == CLS_LOAD) begin
               m_in[0] = f_ff[0];
               m_in[1] = sat32(-ACC_W'(f_ff[2]));
               m_in[2] = f_ff[2];
               m_in[3] = f_ff[0];
               m_in[4] = n_ff[4];
               m_in[5] = n_ff[5];
            end else begin
               m_in = n_ff;
            end
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!valid_ff || rsp_ready) begin
               o_in     = m_ff;
               valid_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         m_ff[0]  <= ONE;
         m_ff[1]  <= '0;
         m_ff[2]  <= '0;
         m_ff[3]  <= ONE;
         m_ff[4]  <= '0;
         m_ff[5]  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         m_ff     <= m_in;
      end
      cmd_ff  <= cmd_in;
      f_ff    <= f_in;
      n_ff    <= n_in;
      o_ff    <= o_in;
      cs_ff   <= cs_in;
      sn_ff   <= sn_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      pc_ff   <= pc_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_m_xx    = o_ff[0];
   assign rsp_m_xy    = o_ff[1];
   assign rsp_m_yx    = o_ff[2];
   assign rsp_m_yy    = o_ff[3];
   assign rsp_trans_x = o_ff[4];
   assign rsp_trans_y = o_ff[5];

endmodule

// ===== hw/rtl/affine_transform_composer.sv =====
// Top level of the 2D affine transform composer.
// Keeps a 2x3 Q16.16 affine matrix, identity after reset, and returns the whole
// matrix after every command. A two-entry command queue sits in front of a
// back end that runs one command at a time through an iterative CORDIC (one
// step a cycle) and a single shared 32x32 multiplier. Identity and unused modes
// go straight to the output, translate and scale run only products, and rotate
// and load run the CORDIC and then their 16 and 6 products.
// New commands are taken into the queue while a result waits on the output.
module affine_transform_composer #(
   parameter int FRAC_BITS    = atc_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [atc_pkg::MODE_W-1:0]  req_mode,
   input  logic signed [31:0]          req_point_x,
   input  logic signed [31:0]          req_point_y,
   input  logic signed [31:0]          req_offset_x,
   input  logic signed [31:0]          req_offset_y,
   input  logic signed [26:0]          req_angle,
   input  logic signed [31:0]          req_scale_x,
   input  logic signed [31:0]          req_scale_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_m_xx,
   output logic signed [31:0]          rsp_m_xy,
   output logic signed [31:0]          rsp_m_yx,
   output logic signed [31:0]          rsp_m_yy,
   output logic signed [31:0]          rsp_trans_x,
   output logic signed [31:0]          rsp_trans_y
);
   import atc_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   atc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_offset_x (req_offset_x),
      .req_offset_y (req_offset_y),
      .req_angle    (req_angle),
      .req_scale_x  (req_scale_x),
      .req_scale_y  (req_scale_y),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop)
   );

   atc_back #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_m_xx    (rsp_m_xx),
      .rsp_m_xy    (rsp_m_xy),
      .rsp_m_yx    (rsp_m_yx),
      .rsp_m_yy    (rsp_m_yy),
      .rsp_trans_x (rsp_trans_x),
      .rsp_trans_y (rsp_trans_y)
   );

endmodule
